>>> sv/ffsa_pkg.sv
// Package: types, constants and state codes for the first-fit segment allocator.
package ffsa_pkg;
  localparam int POOL_BYTES    = 65536;
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int START_W = 16;
  localparam int LEN_W   = 17;
  localparam int SEG_W   = START_W + LEN_W;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOFIT    = 3'd1,
    ST_OUTSIDE  = 3'd2,
    ST_NOTALLOC = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    logic        action;
    logic [16:0] request_size;
    logic [31:0] free_offset;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] granted_offset;
  } out_item_t;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } seg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SPLIT, S_FREE_APPEND, S_SHIFT_RD,
    S_SHIFT_WR, S_DONE
  } fsm_t;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;
endpackage

>>> sv/first_fit_segment_allocator_top.sv
// First-fit segment allocator: one request in, one status result out, free/used tables in RAM.
// Each request is handled alone. An allocate reads the free table one entry at a time
// (S_SCAN_RD, then S_SCAN_CHK) until it finds a fit; an exact fit is then removed by moving
// up the free entries behind it (S_SHIFT_RD, S_SHIFT_WR). A free scans the used table the same
// way and, unless the free table is full, moves up the used entries behind the hit. Entry 0 of
// the free table is loaded at reset as a one-cycle write; requests wait for it.
// The result sits in an output register; the next request is taken the cycle after it has been
// delivered.
module first_fit_segment_allocator_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffsa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ffsa_pkg::out_item_t out_data
);
  import ffsa_pkg::*;

  fsm_t state_r, state_nxt;
  in_item_t req_r, req_nxt;
  logic [CNT_W-1:0] free_cnt_r, free_cnt_nxt, used_cnt_r, used_cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt, lim_r, lim_nxt;
  logic use_free_r, use_free_nxt;   // table being shifted: 1 free, 0 used
  logic init_r, init_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  logic f_we, u_we;
  logic [IDX_W-1:0] f_wa, f_ra, u_wa, u_ra;
  seg_t f_wd, u_wd, f_rd, u_rd;

  ffsa_ram #(.WIDTH(SEG_W), .DEPTH(TABLE_ENTRIES)) u_free (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
  ffsa_ram #(.WIDTH(SEG_W), .DEPTH(TABLE_ENTRIES)) u_used (
    .clk(clk), .we(u_we), .waddr(u_wa), .wdata(u_wd), .raddr(u_ra), .rdata(u_rd));

  logic [LEN_W-1:0] size_w;
  logic is_alloc;
  logic fit, match;
  assign size_w   = req_r.request_size;
  assign is_alloc = (req_r.action == ACT_ALLOC);
  assign fit      = (f_rd.len >= size_w);
  assign match    = ({16'd0, u_rd.start} == req_r.free_offset);

  assign in_ready  = (state_r == S_IDLE) && init_r && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid && in_ready) state_nxt = S_SCAN_RD;
      S_SCAN_RD: begin
        if (!is_alloc && req_r.free_offset >= 32'(POOL_BYTES)) state_nxt = S_DONE;
        else if (idx_r >= (is_alloc ? free_cnt_r : used_cnt_r)) state_nxt = S_DONE;
        else state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (is_alloc) begin
          if (!fit) state_nxt = S_SCAN_RD;
          else if (used_cnt_r >= CNT_W'(TABLE_ENTRIES)) state_nxt = S_DONE;
          else if (f_rd.len > size_w) state_nxt = S_DONE;
          else state_nxt = S_SHIFT_RD;
        end else begin
          if (!match) state_nxt = S_SCAN_RD;
          else if (free_cnt_r >= CNT_W'(TABLE_ENTRIES)) state_nxt = S_DONE;
          else state_nxt = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: state_nxt = (idx_r + 1'b1 < lim_r) ? S_SHIFT_WR : S_DONE;
      S_SHIFT_WR: state_nxt = S_SHIFT_RD;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    req_nxt = req_r; free_cnt_nxt = free_cnt_r; used_cnt_nxt = used_cnt_r;
    idx_nxt = idx_r; lim_nxt = lim_r; use_free_nxt = use_free_r;
    init_nxt = 1'b1; out_valid_nxt = out_valid_r; out_nxt = out_r;
    f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = idx_r[IDX_W-1:0];
    u_we = 1'b0; u_wa = '0; u_wd = '0; u_ra = idx_r[IDX_W-1:0];
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (!init_r) begin
      f_we = 1'b1;
      f_wd.start = '0;
      f_wd.len = LEN_W'(POOL_BYTES);
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          req_nxt = in_data; idx_nxt = '0;
          out_nxt.status = ST_NOFIT; out_nxt.granted_offset = '0;
        end
      end
      S_SCAN_RD: begin
        if (!is_alloc && req_r.free_offset >= 32'(POOL_BYTES)) out_nxt.status = ST_OUTSIDE;
        else if (!is_alloc) out_nxt.status = ST_NOTALLOC;
      end
      S_SCAN_CHK: begin
        if (is_alloc) begin
          if (!fit) idx_nxt = idx_r + 1'b1;
          else if (used_cnt_r >= CNT_W'(TABLE_ENTRIES)) out_nxt.status = ST_FULL;
          else begin
            out_nxt.status = ST_OK;
            out_nxt.granted_offset = f_rd.start;
            u_we = 1'b1; u_wa = used_cnt_r[IDX_W-1:0];
            u_wd.start = f_rd.start; u_wd.len = size_w;
            used_cnt_nxt = used_cnt_r + 1'b1;
            if (f_rd.len > size_w) begin
              f_we = 1'b1; f_wa = idx_r[IDX_W-1:0];
              f_wd.start = f_rd.start + size_w[START_W-1:0];
              f_wd.len = f_rd.len - size_w;
            end else begin
              use_free_nxt = 1'b1; lim_nxt = free_cnt_r;
              free_cnt_nxt = free_cnt_r - 1'b1;
            end
          end
        end else begin
          if (!match) idx_nxt = idx_r + 1'b1;
          else if (free_cnt_r >= CNT_W'(TABLE_ENTRIES)) out_nxt.status = ST_FULL;
          else begin
            out_nxt.status = ST_OK;
            f_we = 1'b1; f_wa = free_cnt_r[IDX_W-1:0]; f_wd = u_rd;
            free_cnt_nxt = free_cnt_r + 1'b1;
            use_free_nxt = 1'b0; lim_nxt = used_cnt_r;
            used_cnt_nxt = used_cnt_r - 1'b1;
          end
        end
      end
      S_SHIFT_RD: begin
        // fetch entry idx+1, written to idx next cycle
        f_ra = IDX_W'(idx_r + 1'b1);
        u_ra = IDX_W'(idx_r + 1'b1);
      end
      S_SHIFT_WR: begin
        if (use_free_r) begin
          f_we = 1'b1; f_wa = idx_r[IDX_W-1:0]; f_wd = f_rd;
        end else begin
          u_we = 1'b1; u_wa = idx_r[IDX_W-1:0]; u_wd = u_rd;
        end
        idx_nxt = idx_r + 1'b1;
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        if (out_nxt.status != ST_OK) out_nxt.granted_offset = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; free_cnt_r <= CNT_W'(1); used_cnt_r <= '0;
      init_r <= 1'b0; out_valid_r <= 1'b0; idx_r <= '0;
    end else begin
      state_r <= state_nxt; free_cnt_r <= free_cnt_nxt; used_cnt_r <= used_cnt_nxt;
      init_r <= init_nxt; out_valid_r <= out_valid_nxt; idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt; lim_r <= lim_nxt; use_free_r <= use_free_nxt;
    out_r <= out_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= CNT_W'(TABLE_ENTRIES) && used_cnt_r <= CNT_W'(TABLE_ENTRIES))
    else $error("count over table size");
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while busy");
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid_r)
    else $error("result lost");
  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != ST_OK) |-> out_r.granted_offset == '0)
    else $error("offset on failed request");
endmodule

>>> sv/ffsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module ffsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> dv/ffsa_checker.sv
// Checker: watches both channels, predicts allocator results and compares them.
`timescale 1ns / 100ps
module ffsa_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  ffsa_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  ffsa_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);
  import ffsa_pkg::*;

  logic [START_W-1:0] free_start [TABLE_ENTRIES];
  logic [LEN_W-1:0]   free_len   [TABLE_ENTRIES];
  int                 free_cnt;
  logic [START_W-1:0] used_start [TABLE_ENTRIES];
  logic [LEN_W-1:0]   used_len   [TABLE_ENTRIES];
  int                 used_cnt;
  out_item_t          expected_q [$];

  assign pending = expected_q.size();

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic out_item_t predict_request(input in_item_t req);
    out_item_t r;
    r = '0;
    if (req.action == ACT_ALLOC) begin
      r.status = ST_NOFIT;
      for (int i = 0; i < free_cnt; i++) begin
        if (free_len[i] >= req.request_size) begin
          if (used_cnt >= TABLE_ENTRIES) begin
            r.status = ST_FULL;
          end else begin
            used_start[used_cnt] = free_start[i];
            used_len[used_cnt] = req.request_size;
            used_cnt++;
            r.status = ST_OK;
            r.granted_offset = free_start[i];
            if (free_len[i] > req.request_size) begin
              free_start[i] = free_start[i] + req.request_size[15:0];
              free_len[i] = free_len[i] - req.request_size;
            end else begin
              for (int j = i; j + 1 < free_cnt; j++) begin
                free_start[j] = free_start[j+1];
                free_len[j] = free_len[j+1];
              end
              free_cnt--;
            end
          end
          break;
        end
      end
    end else if (req.free_offset >= POOL_BYTES) begin
      r.status = ST_OUTSIDE;
    end else begin
      r.status = ST_NOTALLOC;
      for (int i = 0; i < used_cnt; i++) begin
        if (used_start[i] == req.free_offset[15:0]) begin
          if (free_cnt >= TABLE_ENTRIES) begin
            r.status = ST_FULL;
          end else begin
            free_start[free_cnt] = used_start[i];
            free_len[free_cnt] = used_len[i];
            free_cnt++;
            for (int j = i; j + 1 < used_cnt; j++) begin
              used_start[j] = used_start[j+1];
              used_len[j] = used_len[j+1];
            end
            used_cnt--;
            r.status = ST_OK;
          end
          break;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      free_start[0] <= '0;
      free_len[0] <= LEN_W'(POOL_BYTES);
      free_cnt <= 1;
      used_cnt <= 0;
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (in_valid && in_ready) expected_q = {expected_q, predict_request(in_data)};
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result %p", out_data));
        end else begin
          e = expected_q.pop_front();
          if (out_data.status !== e.status)
            report($sformatf("status %0d, want %0d", out_data.status, e.status));
          if (out_data.granted_offset !== e.granted_offset)
            report($sformatf("offset %0h, want %0h", out_data.granted_offset,
                             e.granted_offset));
        end
      end
    end
  end
endmodule

>>> dv/tb_first_fit_segment_allocator_top.sv
// Testbench top: drives allocate/free requests with random gaps and stalls, gives the verdict.
`timescale 1ns / 100ps
module tb_first_fit_segment_allocator_top;
  import ffsa_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        cycles = 0;
  bit        hold_off = 1'b0;
  logic [15:0] granted_q [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  first_fit_segment_allocator_top u_dut (.*);

  ffsa_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("first_fit_segment_allocator_top test failed");
      $finish;
    end
  end

  // receiver: own stall pattern, long hold-off on request
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else if (cycles % 200 < 60) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // remember granted offsets so frees mostly hit live segments
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready && out_data.status == ST_OK &&
        out_data.granted_offset != 0)
      granted_q = {granted_q, out_data.granted_offset};
  end

  task automatic send(input logic act, input logic [16:0] sz, input logic [31:0] off);
    in_data <= '{action: act, request_size: sz, free_offset: off};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random();
    int  k;
    int  idx;
    logic [31:0] off;
    k = $urandom_range(0, 99);
    if (k < 45) begin
      if ($urandom_range(0, 9) == 0) send(ACT_ALLOC, 17'($urandom_range(0, 65536)), $urandom);
      else send(ACT_ALLOC, 17'($urandom_range(0, 2048)), $urandom);
    end else if (k < 85 && granted_q.size() > 0) begin
      idx = $urandom_range(0, granted_q.size() - 1);
      off = granted_q[idx];
      granted_q.delete(idx);
      send(ACT_FREE, 17'($urandom), off);
    end else if (k < 92) begin
      send(ACT_FREE, 17'($urandom), $urandom);
    end else begin
      send(ACT_FREE, 17'($urandom), 32'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    int gap;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, zero size, outside pool, not allocated, table full
    send(ACT_ALLOC, 17'd0, 32'hFFFF_FFFF);
    send(ACT_FREE, 17'h1FFFF, 32'd0);
    send(ACT_FREE, 17'd0, 32'hFFFF_FFFF);
    send(ACT_FREE, 17'd0, 32'd65536);
    send(ACT_FREE, 17'd0, 32'd65535);
    send(ACT_ALLOC, 17'd65537, 32'd0);
    send(ACT_ALLOC, 17'd65536, 32'd0);
    send(ACT_ALLOC, 17'd1, 32'd0);
    send(ACT_FREE, 17'd0, 32'd0);
    send(ACT_ALLOC, 17'd0, 32'd0);
    send(ACT_ALLOC, 17'd1, 32'd0);
    send(ACT_FREE, 17'd0, 32'd0);
    send(ACT_FREE, 17'd0, 32'd0);
    send(ACT_FREE, 17'd0, 32'd0);
    send(ACT_ALLOC, 17'd0, 32'd0);
    send(ACT_ALLOC, 17'd65536, 32'd0);
    for (int i = 0; i < 66; i++) send(ACT_ALLOC, 17'd1, 32'd0);
    for (int i = 0; i < 66; i++) send(ACT_FREE, 17'd0, 32'(i));
    for (int i = 0; i < 66; i++) send(ACT_ALLOC, 17'd1, 32'd0);
    in_valid <= 1'b0;
    // long receiver hold-off while requests keep coming
    hold_off <= 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
      end
      for (int i = 0; i < 8; i++) send_random();
    join
    in_valid <= 1'b0;
    for (int n = 0; n < 560; ) begin
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
      for (int b = $urandom_range(1, 12); b > 0; b--) begin
        send_random();
        n++;
      end
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("first_fit_segment_allocator_top test passed");
    else $display("first_fit_segment_allocator_top test failed");
    $finish;
  end
endmodule

>>> files.f
sv/ffsa_pkg.sv
sv/ffsa_ram.sv
sv/first_fit_segment_allocator_top.sv
dv/ffsa_checker.sv
dv/tb_first_fit_segment_allocator_top.sv
